### hdl/sbs_pkg.sv
// shared types and constants for the streaming bounding sphere block
package sbs_pkg;

    // coordinate width; fraction position does not affect any bit of the arithmetic
    localparam int CW  = 32;
    // squared distance width: three squares of (CW+1)-bit magnitudes
    localparam int D2W = 2 * CW + 2;
    // iteration counter width, counts 0 .. CW
    localparam int CNTW = $clog2(CW + 1);

    // input item
    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic                 first_point;
        logic                 last_point;
    } t_point;

    // result item
    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic        [CW-1:0] sphere_radius;
        logic                 grew;
        logic                 set_done;
    } t_sphere;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_XX = 3'd0,
        MUL_YY = 3'd1,
        MUL_ZZ = 3'd2,
        MUL_RR = 3'd3,
        MUL_XG = 3'd4,
        MUL_YG = 3'd5,
        MUL_ZG = 3'd6
    } t_mul_sel;

    // controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       set_start;
        logic       offs;
        t_mul_sel   mul_sel;
        logic       acc_clr;
        logic       acc_add;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       grow;
        logic [2:0] div_load;
        logic       div_step;
        logic       update;
        logic       no_grow;
        logic       out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic first;
        logic outside;
        logic out_busy;
    } t_status;

endpackage

### hdl/sbs_ctrl.sv
// sequencing state machine for the bounding sphere update
module sbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sbs_pkg::t_status i_status,
    output sbs_pkg::t_cmd    o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_SET  = 15'b000000000000010,
        S_OFFS = 15'b000000000000100,
        S_MULX = 15'b000000000001000,
        S_MULY = 15'b000000000010000,
        S_MULZ = 15'b000000000100000,
        S_MULR = 15'b000000001000000,
        S_CMP  = 15'b000000010000000,
        S_SQRT = 15'b000000100000000,
        S_GROW = 15'b000001000000000,
        S_PRDX = 15'b000010000000000,
        S_PRDY = 15'b000100000000000,
        S_PRDZ = 15'b001000000000000,
        S_DIV  = 15'b010000000000000,
        S_DONE = 15'b100000000000000
    } t_state;

    localparam logic [sbs_pkg::CNTW-1:0] CNT_LAST = sbs_pkg::CNTW'(sbs_pkg::CW);

    t_state                    r_state, n_state;
    logic [sbs_pkg::CNTW-1:0]  r_cnt, n_cnt;
    logic                      r_div_tail, n_div_tail;

    // state and iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_div_tail <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_div_tail <= n_div_tail;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_div_tail = r_div_tail;
        o_cmd      = '0;
        o_cmd.mul_sel = sbs_pkg::MUL_XX;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_OFFS;
                end
            end
            S_SET: begin
                o_cmd.set_start = 1'b1;
                n_state         = S_DONE;
            end
            S_OFFS: begin
                o_cmd.offs = 1'b1;
                n_state    = i_status.first ? S_SET : S_MULX;
            end
            S_MULX: begin
                o_cmd.mul_sel = sbs_pkg::MUL_XX;
                n_state       = S_MULY;
            end
            S_MULY: begin
                o_cmd.mul_sel = sbs_pkg::MUL_YY;
                o_cmd.acc_clr = 1'b1;
                n_state       = S_MULZ;
            end
            S_MULZ: begin
                o_cmd.mul_sel = sbs_pkg::MUL_ZZ;
                o_cmd.acc_add = 1'b1;
                n_state       = S_MULR;
            end
            S_MULR: begin
                o_cmd.mul_sel = sbs_pkg::MUL_RR;
                o_cmd.acc_add = 1'b1;
                n_state       = S_CMP;
            end
            S_CMP: begin
                if (i_status.outside) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_SQRT;
                end else begin
                    o_cmd.no_grow = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_GROW;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_GROW: begin
                o_cmd.grow = 1'b1;
                n_state    = S_PRDX;
            end
            S_PRDX: begin
                o_cmd.mul_sel = sbs_pkg::MUL_XG;
                n_state       = S_PRDY;
            end
            S_PRDY: begin
                o_cmd.mul_sel     = sbs_pkg::MUL_YG;
                o_cmd.div_load[0] = 1'b1;
                n_state           = S_PRDZ;
            end
            S_PRDZ: begin
                o_cmd.mul_sel     = sbs_pkg::MUL_ZG;
                o_cmd.div_load[1] = 1'b1;
                n_state           = S_DIV;
                n_cnt             = '0;
                n_div_tail        = 1'b1;
            end
            S_DIV: begin
                // first cycle loads the z divider from the last product
                if (r_div_tail) begin
                    o_cmd.div_load[2] = 1'b1;
                    n_div_tail        = 1'b0;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        o_cmd.update = 1'b1;
                        n_state      = S_DONE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/sbs_dp.sv
// datapath: shared multiplier, square root and three dividers for the sphere update
module sbs_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sbs_pkg::t_point  i_in_data,
    input  sbs_pkg::t_cmd    i_cmd,
    output sbs_pkg::t_status o_status,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sbs_pkg::t_sphere o_out_data
);

    localparam int CW  = sbs_pkg::CW;
    localparam int D2W = sbs_pkg::D2W;
    localparam int SRW = CW + 4;

    // latched point and held sphere
    sbs_pkg::t_point         r_pt;
    logic signed [CW-1:0]    r_c [3];
    logic        [CW-1:0]    r_rad;
    logic                    r_grew;

    // offsets
    logic        [CW:0]      r_mag [3];
    logic                    r_neg [3];

    // multiplier and accumulator
    logic [CW:0]             mul_a, mul_b;
    logic [D2W-1:0]          r_prod, r_d2;

    // square root
    logic [D2W-1:0]          r_sn;
    logic [SRW-1:0]          r_srem;
    logic [CW:0]             r_root;
    logic [SRW-1:0]          s_shift, s_trial;

    // growth
    logic [CW:0]             r_nr, r_grw;
    logic [CW+1:0]           s_sum;

    // dividers
    logic [CW:0]             r_drem [3];
    logic [CW:0]             r_dlo  [3];
    logic [CW:0]             r_q    [3];

    // output register
    logic                    r_out_valid;
    sbs_pkg::t_sphere        r_out;

    logic signed [CW-1:0]    s_p [3];

    assign s_p[0] = r_pt.point_x;
    assign s_p[1] = r_pt.point_y;
    assign s_p[2] = r_pt.point_z;

    // input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_pt <= i_in_data;
        end
    end

    // axis offsets, sign and magnitude
    always_ff @(posedge i_clk) begin
        if (i_cmd.offs) begin
            for (int a = 0; a < 3; a++) begin
                logic signed [CW:0] dv;
                dv = {s_p[a][CW-1], s_p[a]} - {r_c[a][CW-1], r_c[a]};
                r_neg[a] <= dv[CW];
                r_mag[a] <= dv[CW] ? (CW+1)'(-dv) : dv;
            end
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            sbs_pkg::MUL_XX: begin mul_a = r_mag[0];       mul_b = r_mag[0];       end
            sbs_pkg::MUL_YY: begin mul_a = r_mag[1];       mul_b = r_mag[1];       end
            sbs_pkg::MUL_ZZ: begin mul_a = r_mag[2];       mul_b = r_mag[2];       end
            sbs_pkg::MUL_RR: begin mul_a = {1'b0, r_rad};  mul_b = {1'b0, r_rad};  end
            sbs_pkg::MUL_XG: begin mul_a = r_mag[0];       mul_b = r_grw;          end
            sbs_pkg::MUL_YG: begin mul_a = r_mag[1];       mul_b = r_grw;          end
            sbs_pkg::MUL_ZG: begin mul_a = r_mag[2];       mul_b = r_grw;          end
            default:         begin mul_a = '0;             mul_b = '0;             end
        endcase
    end

    // registered product and squared distance sum
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.acc_clr) begin
            r_d2 <= r_prod;
        end else if (i_cmd.acc_add) begin
            r_d2 <= r_d2 + r_prod;
        end
    end

    // digit-by-digit square root, one result bit per cycle
    assign s_shift = {r_srem[SRW-3:0], r_sn[D2W-1 -: 2]};
    assign s_trial = SRW'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_sn   <= r_d2;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sn <= {r_sn[D2W-3:0], 2'b00};
            if (s_shift >= s_trial) begin
                r_srem <= s_shift - s_trial;
                r_root <= {r_root[CW-1:0], 1'b1};
            end else begin
                r_srem <= s_shift;
                r_root <= {r_root[CW-1:0], 1'b0};
            end
        end
    end

    // new radius and growth amount
    assign s_sum = {1'b0, r_root} + {2'b00, r_rad};

    always_ff @(posedge i_clk) begin
        if (i_cmd.grow) begin
            r_nr  <= s_sum[CW+1:1];
            r_grw <= s_sum[CW+1:1] - {1'b0, r_rad};
        end
    end

    // restoring dividers, one quotient bit per cycle on each axis
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            logic [CW+1:0] tr;
            tr = {r_drem[a], r_dlo[a][CW]};
            if (i_cmd.div_load[a]) begin
                r_drem[a] <= r_prod[D2W-1:CW+1];
                r_dlo[a]  <= r_prod[CW:0];
                r_q[a]    <= '0;
            end else if (i_cmd.div_step) begin
                r_dlo[a] <= {r_dlo[a][CW-1:0], 1'b0};
                if (tr >= {1'b0, r_root}) begin
                    r_drem[a] <= (CW+1)'(tr - {1'b0, r_root});
                    r_q[a]    <= {r_q[a][CW-1:0], 1'b1};
                end else begin
                    r_drem[a] <= tr[CW:0];
                    r_q[a]    <= {r_q[a][CW-1:0], 1'b0};
                end
            end
        end
    end

    // held sphere
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_c[a] <= '0;
            end
            r_rad  <= '0;
            r_grew <= 1'b0;
        end else if (i_cmd.set_start) begin
            for (int a = 0; a < 3; a++) begin
                r_c[a] <= s_p[a];
            end
            r_rad  <= '0;
            r_grew <= 1'b0;
        end else if (i_cmd.no_grow) begin
            r_grew <= 1'b0;
        end else if (i_cmd.update) begin
            // last quotient bit is taken from the divider inputs directly
            for (int a = 0; a < 3; a++) begin
                logic [CW+1:0] tr;
                logic [CW:0]   qv;
                logic [CW:0]   cs;
                tr = {r_drem[a], r_dlo[a][CW]};
                qv = {r_q[a][CW-1:0], (tr >= {1'b0, r_root})};
                cs = {r_c[a][CW-1], r_c[a]} + (r_neg[a] ? (CW+1)'(-qv) : qv);
                r_c[a] <= cs[CW-1:0];
            end
            r_rad  <= r_nr[CW] ? '1 : r_nr[CW-1:0];
            r_grew <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.center_x      <= r_c[0];
            r_out.center_y      <= r_c[1];
            r_out.center_z      <= r_c[2];
            r_out.sphere_radius <= r_rad;
            r_out.grew          <= r_grew;
            r_out.set_done      <= r_pt.last_point;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;
    assign o_status.first    = r_pt.first_point;
    assign o_status.outside  = (r_d2 > r_prod);
    assign o_status.out_busy = r_out_valid && i_out_stall;

endmodule

### hdl/streaming_bounding_sphere.sv
// top level of the streaming bounding sphere block
// Keeps a running bounding sphere over a stream of signed fixed-point 3-D points and
// gives one result transfer per point: centre, saturating radius, a grew flag and the
// echoed last_point flag. One point is worked on at a time. A first point of a set passes
// the offset and set states before the result is loaded; a point inside the sphere passes
// the offset state, the product states for x, y, z and the radius, and the compare; a
// point that grows the sphere also passes the square root, growth, the product states for
// x, y and z and the divider state. The square root and the three dividers are bit-serial,
// and all products come from one shared 33 x 33 multiplier. The next point is taken in
// the cycle after the result is loaded. The load waits while an earlier result is stalled.
// The result register lets the next point be taken while a finished result still waits
// downstream.
module streaming_bounding_sphere (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sbs_pkg::t_point  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sbs_pkg::t_sphere o_out_data
);

    sbs_pkg::t_cmd    cmd;
    sbs_pkg::t_status status;

    // controller
    sbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    sbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### test/streaming_bounding_sphere_chk.sv
// checker for the streaming bounding sphere block: predicts spheres and compares results
module streaming_bounding_sphere_chk (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  sbs_pkg::t_point  i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  sbs_pkg::t_sphere i_out_data,
    output int               o_fail_count,
    output int               o_pending
);
    import sbs_pkg::*;

    logic signed [CW-1:0] ctr_x, ctr_y, ctr_z;
    logic        [CW-1:0] rad;
    t_sphere              sphere_q[$];

    // floored square root of a squared distance
    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0]  res;
        logic [63:0]  cand;
        res = '0;
        for (int i = 62; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            if (128'(cand) * 128'(cand) <= n) res = cand;
        end
        return res;
    endfunction

    // move one centre axis toward the point, truncated toward zero
    function automatic logic signed [CW-1:0] shift_axis(logic signed [CW-1:0] c,
                                                        logic signed [63:0] off,
                                                        logic [63:0] grow,
                                                        logic [63:0] d);
        logic [63:0]  m;
        logic [127:0] q;
        m = off < 0 ? 64'(-off) : 64'(off);
        q = (128'(m) * 128'(grow)) / 128'(d);
        if (off < 0) return CW'(64'(c) - q[63:0]);
        return CW'(64'(c) + q[63:0]);
    endfunction

    // next sphere from one point transfer
    function automatic t_sphere grow_sphere(t_point p);
        t_sphere            s;
        logic signed [63:0] dx, dy, dz;
        logic [63:0]        mx, my, mz, d, nr, r;
        logic [127:0]       d2;
        s = '0;
        if (p.first_point) begin
            ctr_x = p.point_x;
            ctr_y = p.point_y;
            ctr_z = p.point_z;
            rad   = '0;
        end else begin
            dx = 64'(p.point_x) - 64'(ctr_x);
            dy = 64'(p.point_y) - 64'(ctr_y);
            dz = 64'(p.point_z) - 64'(ctr_z);
            mx = dx < 0 ? 64'(-dx) : 64'(dx);
            my = dy < 0 ? 64'(-dy) : 64'(dy);
            mz = dz < 0 ? 64'(-dz) : 64'(dz);
            d2 = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
            r  = 64'(rad);
            if (d2 > 128'(r) * 128'(r)) begin
                d  = isqrt(d2);
                nr = (d + r) >> 1;
                s.grew = 1'b1;
                ctr_x = shift_axis(ctr_x, dx, nr - r, d);
                ctr_y = shift_axis(ctr_y, dy, nr - r, d);
                ctr_z = shift_axis(ctr_z, dz, nr - r, d);
                rad   = nr > 64'hFFFF_FFFF ? '1 : CW'(nr);
            end
        end
        s.center_x      = ctr_x;
        s.center_y      = ctr_y;
        s.center_z      = ctr_z;
        s.sphere_radius = rad;
        s.set_done      = p.last_point;
        return s;
    endfunction

    assign o_pending = sphere_q.size();

    // predict on input transfer, compare on result transfer
    always @(posedge i_clk) begin
        t_sphere e;
        if (!i_rst_n) begin
            ctr_x <= '0;
            ctr_y <= '0;
            ctr_z <= '0;
            rad   <= '0;
            o_fail_count <= 0;
            sphere_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) sphere_q.push_back(grow_sphere(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (sphere_q.size() == 0) begin
                    $display("%0t unexpected result %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = sphere_q.pop_front();
                    if (e !== i_out_data) begin
                        $display("%0t mismatch expected %h actual %h", $time, e, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### test/streaming_bounding_sphere_tb.sv
// testbench top for the streaming bounding sphere block: stimulus and verdict
module streaming_bounding_sphere_tb;
    import sbs_pkg::*;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    t_point  in_data = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    t_sphere out_data;
    int      fails, pending;
    bit      calm = 1'b0;

    always #5 clk = ~clk;

    streaming_bounding_sphere dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_in_data(in_data), .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_data(out_data)
    );

    streaming_bounding_sphere_chk chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_in_data(in_data), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_data(out_data), .o_fail_count(fails), .o_pending(pending)
    );

    // random coordinate: extremes, small spreads or full range
    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3, 4: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< 8;
            5, 6:    return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    // receiver stalls, single cycles or bursts
    always @(posedge clk) begin
        if (calm) begin
            out_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 12) - 1) @(posedge clk);
        end else if ($urandom_range(0, 3) != 0) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= 1'b1;
        end
    end

    // one point transfer, with an optional idle burst before it
    task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                              logic f, logic l);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{x, y, z, f, l};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial begin
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: no start seen, extremes, one-point set, tiny growth
        send_point(32'h0000_0001, 32'h0, 32'h0, 1'b0, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
        send_point(32'h1234_5678, 32'h8765_4321, 32'h0, 1'b1, 1'b1);
        send_point(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
        send_point(32'h0000_0001, 32'h0, 32'h0, 1'b0, 1'b0);
        send_point(32'h0000_0001, 32'h0000_0001, 32'h0, 1'b0, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_point(32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b0);
        send_point(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b1);
        // random sets of mostly well-formed shape
        n = 0;
        while (n < 1500) begin
            int len;
            len = $urandom_range(1, 12);
            if (n > 1300) calm = 1'b1;
            for (int k = 0; k < len; k++) begin
                send_point(pick_coord(), pick_coord(), pick_coord(),
                           k == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 30) == 0),
                           k == len - 1 ? ($urandom_range(0, 9) != 0)
                                        : 1'($urandom_range(0, 1)));
                n++;
            end
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fails == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end
endmodule

### files.f
hdl/sbs_pkg.sv
hdl/sbs_ctrl.sv
hdl/sbs_dp.sv
hdl/streaming_bounding_sphere.sv
test/streaming_bounding_sphere_chk.sv
test/streaming_bounding_sphere_tb.sv
